### design/dma_job_list_walker_unit_defines.svh
// ---------------------------------------------------------------------------
// DMA job-list walker assertion macros
// Shared concurrent assertion forms for the walker's modules.
// ---------------------------------------------------------------------------
`ifndef DMA_JOB_LIST_WALKER_UNIT_DEFINES_SVH
`define DMA_JOB_LIST_WALKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define DJW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define DJW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/djw_pkg.sv
// ---------------------------------------------------------------------------
// DMA job-list walker package
// Types, codes, field layout and command/status bundles shared by the walker.
// ---------------------------------------------------------------------------
package djw_pkg;

    // Default number of descriptor slots and the per-access segment cap.
    localparam int JOB_DEPTH_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int CNT_W         = $clog2(MAX_RESULTS);

    // Field widths.
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 24;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 4;

    // Input tdata layout, lowest bit first.
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_ADDR_LSB  = IN_IDX_LSB + IDX_W;
    localparam int IN_ATTR_LSB  = IN_ADDR_LSB + ADDR_W;
    localparam int IN_LEN_LSB   = IN_ATTR_LSB + ATTR_W;
    localparam int IN_PRES_BIT  = IN_LEN_LSB + LEN_W;
    localparam int IN_RNW_BIT   = IN_PRES_BIT + 1;
    localparam int IN_CNT_LSB   = IN_RNW_BIT + 1;
    localparam int IN_NEW_BIT   = IN_CNT_LSB + LEN_W;
    localparam int IN_DATA_W    = 96;

    // Output tdata layout, lowest bit first.
    localparam int OUT_ADDR_LSB  = 0;
    localparam int OUT_LEN_LSB   = OUT_ADDR_LSB + ADDR_W;
    localparam int OUT_OFF_LSB   = OUT_LEN_LSB + LEN_W;
    localparam int OUT_MOVED_LSB = OUT_OFF_LSB + LEN_W;
    localparam int OUT_ST_LSB    = OUT_MOVED_LSB + LEN_W;
    localparam int OUT_USED_W    = OUT_ST_LSB + 3;
    localparam int OUT_DATA_W    = 112;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_ACCESS = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_COMPLETE = 3'd0,
        ST_PARTIAL  = 3'd1,
        ST_END      = 3'd2,
        ST_NO_LIST  = 3'd3,
        ST_DIR_ERR  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_dir;

    // One descriptor table entry.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ATTR_W-1:0] attr;
        logic [LEN_W-1:0]  len;
    } t_desc;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_wr;
        logic    start;
        logic    begin_acc;
        logic    fetch;
        logic    clear_cur;
        logic    seg_step;
        logic    emit;
        logic    emit_zero;
        t_status emit_st;
        logic    emit_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic list_present;
        logic list_valid;
        logic dir_mismatch;
        logic need_fetch;
        logic at_end;
        logic attr_match;
        logic seg_done;
        logic out_free;
    } t_sts;

endpackage

### design/djw_datapath.sv
// ---------------------------------------------------------------------------
// DMA job-list walker datapath
// Descriptor table, walk registers, segment arithmetic and result register.
// ---------------------------------------------------------------------------
module djw_datapath #(
    parameter int JOB_DEPTH = djw_pkg::JOB_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [djw_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  logic [1:0]                    i_s_axis_tuser,
    input  djw_pkg::t_cmd                 i_cmd,
    output djw_pkg::t_sts                 o_sts,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [djw_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);
    import djw_pkg::*;

    localparam int AW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int NW = $clog2(JOB_DEPTH + 1);
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    // Input fields.
    logic [IDX_W-1:0]  in_idx;
    t_desc             in_desc;
    logic              in_present;
    logic              in_rnw;
    logic [LEN_W-1:0]  in_count;
    logic              in_new;
    logic [XW-1:0]     in_idx_wide;
    logic [AW-1:0]     wr_idx;
    logic              wr_ok;
    t_dir              want_dir;

    assign in_idx       = i_s_axis_tdata[IN_IDX_LSB +: IDX_W];
    assign in_desc.addr = i_s_axis_tdata[IN_ADDR_LSB +: ADDR_W];
    assign in_desc.attr = i_s_axis_tdata[IN_ATTR_LSB +: ATTR_W];
    assign in_desc.len  = i_s_axis_tdata[IN_LEN_LSB +: LEN_W];
    assign in_present   = i_s_axis_tdata[IN_PRES_BIT];
    assign in_rnw       = i_s_axis_tdata[IN_RNW_BIT];
    assign in_count     = i_s_axis_tdata[IN_CNT_LSB +: LEN_W];
    assign in_new       = i_s_axis_tdata[IN_NEW_BIT];
    assign in_idx_wide  = XW'(in_idx);
    assign wr_idx       = in_idx_wide[AW-1:0];
    assign wr_ok        = (32'(in_idx) < JOB_DEPTH);
    assign want_dir     = in_rnw ? MODE_READ : MODE_WRITE;

    // Walk state.
    logic [NW-1:0]     r_next_idx;
    logic [ADDR_W-1:0] r_cur_addr;
    logic [LEN_W-1:0]  r_pend_len;
    logic [ATTR_W-1:0] r_cur_attr;
    t_dir              r_dir;
    logic              r_list_valid;

    // Per-access working registers.
    logic [LEN_W-1:0]  r_req;
    logic [LEN_W-1:0]  r_moved;
    logic [ADDR_W-1:0] r_seg_addr;
    logic [LEN_W-1:0]  r_seg_len;
    logic [LEN_W-1:0]  r_seg_off;
    logic              r_seg_done;

    // Descriptor table with registered read at the walk index.
    t_desc             r_mem [JOB_DEPTH];
    t_desc             r_rd;
    logic              past_depth;
    logic [AW-1:0]     rd_idx;

    assign past_depth = (r_next_idx >= NW'(JOB_DEPTH));
    assign rd_idx     = past_depth ? '0 : r_next_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && wr_ok) begin
            r_mem[wr_idx] <= in_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_idx];
    end

    // Segment arithmetic: take the smaller of what is asked and what is left.
    logic [LEN_W-1:0] avail;
    logic [LEN_W-1:0] take;
    logic [LEN_W-1:0] moved_sum;

    assign avail     = r_req - r_moved;
    assign take      = (avail < r_pend_len) ? avail : r_pend_len;
    assign moved_sum = r_moved + take;

    // Walk state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_idx   <= '0;
            r_cur_addr   <= '0;
            r_pend_len   <= '0;
            r_cur_attr   <= '0;
            r_dir        <= MODE_IDLE;
            r_list_valid <= 1'b0;
        end else if (i_cmd.start) begin
            r_list_valid <= in_present;
            r_next_idx   <= '0;
            r_dir        <= MODE_IDLE;
            r_cur_addr   <= '0;
            r_pend_len   <= '0;
            r_cur_attr   <= '0;
        end else if (i_cmd.begin_acc) begin
            r_dir <= want_dir;
        end else if (i_cmd.fetch) begin
            r_cur_addr <= r_rd.addr;
            r_cur_attr <= r_rd.attr;
            r_pend_len <= r_rd.len;
            r_next_idx <= r_next_idx + 1'b1;
        end else if (i_cmd.clear_cur) begin
            r_cur_addr <= '0;
            r_pend_len <= '0;
        end else if (i_cmd.seg_step) begin
            r_pend_len <= r_pend_len - take;
            r_cur_addr <= r_cur_addr + ADDR_W'(take);
        end
    end

    // Access and segment working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_acc) begin
            r_req   <= in_count;
            r_moved <= '0;
        end else if (i_cmd.seg_step) begin
            r_moved    <= moved_sum;
            r_seg_addr <= r_cur_addr;
            r_seg_len  <= take;
            r_seg_off  <= r_moved;
            r_seg_done <= (moved_sum == r_req);
        end
    end

    // Result register.
    logic                  r_o_valid;
    logic [OUT_USED_W-1:0] r_o_data;
    logic                  r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_last <= i_cmd.emit_last;
            if (i_cmd.emit_zero) begin
                r_o_data <= {i_cmd.emit_st, {(OUT_ST_LSB){1'b0}}};
            end else begin
                r_o_data <= {i_cmd.emit_st, r_moved, r_seg_off, r_seg_len, r_seg_addr};
            end
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_o_data);
    assign o_m_axis_tlast  = r_o_last;

    // Status back to the controller.
    always_comb begin
        o_sts.op           = t_op'(i_s_axis_tuser);
        o_sts.list_present = in_present;
        o_sts.list_valid   = r_list_valid;
        o_sts.dir_mismatch = (r_dir != MODE_IDLE) && (r_dir != want_dir);
        o_sts.need_fetch   = (r_pend_len == '0) || in_new;
        o_sts.at_end       = past_depth || (r_rd.addr == '0);
        o_sts.attr_match   = (r_rd.attr == r_cur_attr);
        o_sts.seg_done     = r_seg_done;
        o_sts.out_free     = !r_o_valid || i_m_axis_tready;
    end

endmodule

### design/djw_ctrl.sv
// ---------------------------------------------------------------------------
// DMA job-list walker controller
// Decodes transactions and sequences job fetches, segments and results.
// ---------------------------------------------------------------------------
`include "dma_job_list_walker_unit_defines.svh"

module djw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  djw_pkg::t_sts i_sts,
    output djw_pkg::t_cmd o_cmd
);
    import djw_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EMIT  = 6'b000010,
        S_RD    = 6'b000100,
        S_FCHK  = 6'b001000,
        S_SEG   = 6'b010000,
        S_CHECK = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    t_status          r_pend_st, n_pend_st;
    logic [CNT_W-1:0] r_seg_cnt, n_seg_cnt;
    logic             accept;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Next-state and command decode.
    always_comb begin
        n_state   = r_state;
        n_pend_st = r_pend_st;
        n_seg_cnt = r_seg_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_sts.op)
                        OP_LOAD: begin
                            o_cmd.load_wr = 1'b1;
                        end
                        OP_START: begin
                            o_cmd.start = 1'b1;
                            n_pend_st   = i_sts.list_present ? ST_COMPLETE : ST_NO_LIST;
                            n_state     = S_EMIT;
                        end
                        OP_ACCESS: begin
                            if (!i_sts.list_valid) begin
                                n_pend_st = ST_NO_LIST;
                                n_state   = S_EMIT;
                            end else if (i_sts.dir_mismatch) begin
                                n_pend_st = ST_DIR_ERR;
                                n_state   = S_EMIT;
                            end else begin
                                o_cmd.begin_acc = 1'b1;
                                n_seg_cnt       = '0;
                                n_state         = i_sts.need_fetch ? S_RD : S_SEG;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_zero = 1'b1;
                    o_cmd.emit_st   = r_pend_st;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (i_sts.at_end) begin
                    o_cmd.clear_cur = 1'b1;
                    n_pend_st       = ST_END;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_SEG;
                end
            end
            S_SEG: begin
                o_cmd.seg_step = 1'b1;
                n_state        = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                    if (i_sts.seg_done) begin
                        o_cmd.emit_st = ST_COMPLETE;
                    end else if (i_sts.at_end) begin
                        o_cmd.emit_st = ST_END;
                    end else if (!i_sts.attr_match) begin
                        o_cmd.emit_st = ST_PARTIAL;
                    end else if (r_seg_cnt == CNT_W'(MAX_RESULTS - 1)) begin
                        o_cmd.emit_st = ST_PARTIAL;
                    end else begin
                        // Cross into the next job with the same attribute.
                        o_cmd.emit_st   = ST_PARTIAL;
                        o_cmd.emit_last = 1'b0;
                        o_cmd.fetch     = 1'b1;
                        n_seg_cnt       = r_seg_cnt + 1'b1;
                        n_state         = S_SEG;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend_st <= ST_COMPLETE;
            r_seg_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_pend_st <= n_pend_st;
            r_seg_cnt <= n_seg_cnt;
        end
    end

    // A result is only written when the result register can take it.
    `DJW_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free, "emit while result register busy")
    // A job is never fetched from past the end of the list.
    `DJW_ASSERT_IMPL(a_fetch_valid, i_clk, i_rst_n, o_cmd.fetch, !i_sts.at_end, "fetch at end of list")
    // Every segment step is checked in the following cycle.
    `DJW_ASSERT_NEXT(a_seg_check, i_clk, i_rst_n, r_state == S_SEG, r_state == S_CHECK, "segment not checked")
    // The final result of a transaction returns the walker to idle.
    `DJW_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_cmd.emit && o_cmd.emit_last, r_state == S_IDLE, "no idle after final result")

endmodule

### design/dma_job_list_walker_unit.sv
// Load transactions give no result; start, no-list and direction-error results
// pass through the emit state, which waits while the result register is busy.
// An access steps through the segment and check states per copy segment, after the
// read state (for the registered table read) and fetch-check state if a job is fetched.
// One input transaction is in work at a time; at most 16 results per access.
// Reset (synchronous, active low) clears the walk state; the table is not cleared.
// ---------------------------------------------------------------------------
// DMA job-list walker top level
// Scatter-gather descriptor walker that splits accesses into copy segments.
// ---------------------------------------------------------------------------
module dma_job_list_walker_unit #(
    parameter int JOB_DEPTH = djw_pkg::JOB_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // desc_index, desc_address, desc_attribute, desc_length, list_present,
    // dir_is_read, byte_count, new_job
    input  logic [djw_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation
    input  logic [1:0]                     i_s_axis_tuser,
    // Result stream.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // segment_address, segment_length, periph_offset, moved_total, status
    output logic [djw_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // last
    output logic                           o_m_axis_tlast
);
    import djw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller state machine.
    djw_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // Table, walk registers and result register.
    djw_datapath #(
        .JOB_DEPTH (JOB_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
